>>> hdl/hrb_pkg.sv
package hrb_pkg;

  // line limits and derived widths
  localparam int MAX_BYTES = 64;
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 2);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  // exit word progress
  localparam logic [2:0] EXIT_DONE = 3'd4;
  localparam logic [2:0] EXIT_MISS = 3'd5;
  localparam logic [4:0] NIB_NONE  = 5'd16;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EXIT  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_WANT_E = 4'd1,
    PH_WANT_X = 4'd2,
    PH_FOURTH = 4'd3,
    PH_SKIP   = 4'd4,
    PH_GAP    = 4'd5,
    PH_ZERO   = 4'd6,
    PH_PREFIX = 4'd7,
    PH_HI     = 4'd8,
    PH_AFTER  = 4'd9,
    PH_RAW    = 4'd10,
    PH_DEAD   = 4'd11
  } phase_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  // one finished line, handed from front to back
  typedef struct packed {
    kind_t            kind;
    logic             src_hex;
    logic             bank;
    logic [CNT_W-1:0] len;
  } line_cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

  // hex digit value, NIB_NONE for anything else
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] d;
    d = NIB_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

  function automatic logic [7:0] exit_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = CH_LO_E;
      3'd1:    c = CH_LO_X;
      3'd2:    c = CH_LO_I;
      3'd3:    c = CH_LO_T;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/hex_or_raw_line_to_bytes_unit.sv
// the first result of a line passes through the line queue, the back end's command register and its output registers
// throughput: one character per cycle in while in_stall is low; results leave one per cycle within a line
// while out_stall is low, with the back end passing through its idle state between lines
// input stalls only while two finished lines still wait for, or are in, the back end,
// set by the two store banks and the two-entry line queue
// reset: synchronous, active low; clears parser, queue and output control at once,
// store contents stay undefined and need no clearing pass
module hex_or_raw_line_to_bytes_unit
  import hrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_line,
  input  logic       in_no_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  logic               take;
  store_wr_t          raw_wr, hex_wr;
  store_rd_t          rd;
  logic               push, pop;
  line_cmd_t          push_cmd, q_head;
  logic               q_not_empty;
  logic [Q_CNT_W-1:0] q_count;
  logic               back_busy;
  logic [7:0]         raw_q, hex_q;
  logic [Q_CNT_W:0]   pending;

  // a bank is reused only once the earlier line that held it is gone
  assign pending  = {1'b0, q_count} + {{Q_CNT_W{1'b0}}, back_busy};
  assign in_stall = pending >= (Q_CNT_W + 1)'(Q_DEPTH);
  assign take     = in_valid & ~in_stall;

  hrb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .char_code   (in_char_code),
    .end_of_line (in_end_of_line),
    .no_char     (in_no_char),
    .raw_wr      (raw_wr),
    .hex_wr      (hex_wr),
    .push        (push),
    .cmd         (push_cmd)
  );

  hrb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_raw_ram (
    .clk   (clk),
    .we    (raw_wr.we),
    .waddr (raw_wr.addr),
    .wdata (raw_wr.data),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (raw_q)
  );

  hrb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_hex_ram (
    .clk   (clk),
    .we    (hex_wr.we),
    .waddr (hex_wr.addr),
    .wdata (hex_wr.data),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (hex_q)
  );

  hrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  hrb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .pop           (pop),
    .rd            (rd),
    .raw_q         (raw_q),
    .hex_q         (hex_q),
    .busy          (back_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

endmodule

>>> hdl/hrb_ram.sv
module hrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/hrb_front.sv
module hrb_front
  import hrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic [7:0] char_code,
  input  logic      end_of_line,
  input  logic      no_char,
  output store_wr_t raw_wr,
  output store_wr_t hex_wr,
  output logic      push,
  output line_cmd_t cmd
);

  phase_t           phase_r, phase_nxt, ph_f;
  logic [CNT_W-1:0] raw_count_r, raw_count_nxt, raw_f;
  logic [CNT_W-1:0] hex_count_r, hex_count_nxt, hex_f;
  logic [3:0]       high_nibble_r, high_nibble_nxt, hn_f;
  logic             hex_error_r, hex_error_nxt, err_f;
  logic [2:0]       exit_match_r, exit_match_nxt, ex_f;
  logic             bank_r, bank_nxt;

  logic       feed;
  logic       blank, sep;
  logic [4:0] d;
  logic       hex_room;
  logic       hex_put;
  logic [7:0] hex_byte;
  logic       hex_mode;

  assign feed     = take & ~no_char;
  assign blank    = (char_code == CH_SPACE) || (char_code == CH_TAB);
  assign sep      = blank || (char_code == CH_COMMA);
  assign d        = nibble_of(char_code);
  assign hex_room = hex_count_r < CNT_W'(MAX_BYTES);

  // character parse, giving the state after this item
  always_comb begin
    ph_f     = phase_r;
    raw_f    = raw_count_r;
    hex_f    = hex_count_r;
    hn_f     = high_nibble_r;
    err_f    = hex_error_r;
    ex_f     = exit_match_r;
    hex_put  = 1'b0;
    hex_byte = 8'h00;
    if (feed) begin
      if (raw_count_r <= CNT_W'(MAX_BYTES)) begin
        raw_f = raw_count_r + CNT_W'(1);
      end
      if (!(phase_r == PH_LEAD && blank)) begin
        if (exit_match_r < EXIT_DONE && char_code == exit_char(exit_match_r)) begin
          ex_f = exit_match_r + 3'd1;
        end else begin
          ex_f = EXIT_MISS;
        end
      end
      unique case (phase_r)
        PH_LEAD: begin
          if (!blank) begin
            ph_f = (char_code == CH_LO_H || char_code == CH_UP_H) ? PH_WANT_E : PH_RAW;
          end
        end
        PH_WANT_E: begin
          ph_f = (char_code == CH_LO_E || char_code == CH_UP_E) ? PH_WANT_X : PH_RAW;
        end
        PH_WANT_X: begin
          ph_f = (char_code == CH_LO_X || char_code == CH_UP_X) ? PH_FOURTH : PH_RAW;
        end
        PH_FOURTH, PH_SKIP, PH_GAP: begin
          if (phase_r == PH_FOURTH && (char_code == CH_COLON || sep)) begin
            ph_f = PH_SKIP;
          end else if (!sep) begin
            // token start
            if (!hex_room) begin
              err_f = 1'b1;
              ph_f  = PH_DEAD;
            end else if (char_code == CH_ZERO) begin
              ph_f = PH_ZERO;
            end else if (d != NIB_NONE) begin
              hn_f = d[3:0];
              ph_f = PH_HI;
            end else begin
              err_f = 1'b1;
              ph_f  = PH_DEAD;
            end
          end
        end
        PH_ZERO: begin
          if (char_code == CH_LO_X || char_code == CH_UP_X) begin
            ph_f = PH_PREFIX;
          end else if (d != NIB_NONE) begin
            hex_put  = 1'b1;
            hex_byte = {4'h0, d[3:0]};
            ph_f     = PH_AFTER;
          end else begin
            err_f = 1'b1;
            ph_f  = PH_DEAD;
          end
        end
        PH_PREFIX: begin
          if (d != NIB_NONE) begin
            hn_f = d[3:0];
            ph_f = PH_HI;
          end else begin
            err_f = 1'b1;
            ph_f  = PH_DEAD;
          end
        end
        PH_HI: begin
          if (d != NIB_NONE) begin
            hex_put  = 1'b1;
            hex_byte = {high_nibble_r, d[3:0]};
            ph_f     = PH_AFTER;
          end else begin
            err_f = 1'b1;
            ph_f  = PH_DEAD;
          end
        end
        PH_AFTER: begin
          if (sep) begin
            ph_f = PH_GAP;
          end else begin
            err_f = 1'b1;
            ph_f  = PH_DEAD;
          end
        end
        default: begin
        end
      endcase
      if (hex_put && hex_room) begin
        hex_f = hex_count_r + CNT_W'(1);
      end
    end
  end

  // store writes into the current bank
  always_comb begin
    raw_wr.we   = feed && (raw_count_r < CNT_W'(MAX_BYTES));
    raw_wr.addr = {bank_r, raw_count_r[IDX_W-1:0]};
    raw_wr.data = char_code;
    hex_wr.we   = hex_put && hex_room;
    hex_wr.addr = {bank_r, hex_count_r[IDX_W-1:0]};
    hex_wr.data = hex_byte;
  end

  // line outcome on the end-of-line item
  assign hex_mode = (ph_f == PH_GAP) || (ph_f == PH_ZERO) || (ph_f == PH_PREFIX) ||
                    (ph_f == PH_HI) || (ph_f == PH_AFTER) || (ph_f == PH_DEAD);
  assign push     = take & end_of_line;

  always_comb begin
    cmd.bank    = bank_r;
    cmd.src_hex = 1'b0;
    cmd.len     = raw_f;
    cmd.kind    = KIND_ERROR;
    priority if (ex_f == EXIT_DONE) begin
      cmd.kind = KIND_EXIT;
    end else if (hex_mode) begin
      cmd.src_hex = 1'b1;
      cmd.len     = hex_f;
      if (err_f || ph_f == PH_ZERO || ph_f == PH_PREFIX || ph_f == PH_HI ||
          hex_f == '0) begin
        cmd.kind = KIND_ERROR;
      end else begin
        cmd.kind = KIND_DATA;
      end
    end else if (raw_f == '0 || raw_f > CNT_W'(MAX_BYTES)) begin
      cmd.kind = KIND_ERROR;
    end else begin
      cmd.kind = KIND_DATA;
    end
  end

  // per-line state returns to reset after each line
  always_comb begin
    if (push) begin
      phase_nxt       = PH_LEAD;
      raw_count_nxt   = '0;
      hex_count_nxt   = '0;
      high_nibble_nxt = 4'h0;
      hex_error_nxt   = 1'b0;
      exit_match_nxt  = 3'd0;
      bank_nxt        = ~bank_r;
    end else begin
      phase_nxt       = ph_f;
      raw_count_nxt   = raw_f;
      hex_count_nxt   = hex_f;
      high_nibble_nxt = hn_f;
      hex_error_nxt   = err_f;
      exit_match_nxt  = ex_f;
      bank_nxt        = bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEAD;
      raw_count_r   <= '0;
      hex_count_r   <= '0;
      high_nibble_r <= 4'h0;
      hex_error_r   <= 1'b0;
      exit_match_r  <= 3'd0;
      bank_r        <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      raw_count_r   <= raw_count_nxt;
      hex_count_r   <= hex_count_nxt;
      high_nibble_r <= high_nibble_nxt;
      hex_error_r   <= hex_error_nxt;
      exit_match_r  <= exit_match_nxt;
      bank_r        <= bank_nxt;
    end
  end

endmodule

>>> hdl/hrb_queue.sv
module hrb_queue
  import hrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  line_cmd_t          push_cmd,
  input  logic               pop,
  output logic               not_empty,
  output line_cmd_t          head,
  output logic [Q_CNT_W-1:0] count
);

  line_cmd_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

>>> hdl/hrb_back.sv
module hrb_back
  import hrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  line_cmd_t  q_head,
  output logic       pop,
  output store_rd_t  rd,
  input  logic [7:0] raw_q,
  input  logic [7:0] hex_q,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  bk_state_t        state_r, state_nxt;
  line_cmd_t        cmd_r, cmd_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_src_r, out_src_nxt;

  logic can_load;
  logic final_one;

  assign can_load  = ~out_valid_r | ~out_stall;
  assign final_one = (cmd_r.kind != KIND_DATA) || (idx_r + CNT_W'(1) == cmd_r.len);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (can_load && final_one) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // pop, store reads and output register loads
  always_comb begin
    pop           = 1'b0;
    rd.re         = 1'b0;
    rd.addr       = {cmd_r.bank, idx_r[IDX_W-1:0]};
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_src_nxt   = out_src_r;
    unique case (state_r)
      BK_IDLE: begin
        pop     = q_not_empty;
        cmd_nxt = q_head;
        idx_nxt = '0;
        if (can_load) begin
          out_valid_nxt = 1'b0;
        end
      end
      BK_RUN: begin
        if (can_load) begin
          rd.re         = cmd_r.kind == KIND_DATA;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = cmd_r.kind;
          out_last_nxt  = final_one;
          out_src_nxt   = cmd_r.src_hex;
          idx_nxt       = idx_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_src_r  <= out_src_nxt;
  end

  // result fields
  assign busy          = state_r == BK_RUN;
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_last      = out_last_r;
  assign out_data_byte = (out_kind_r == KIND_DATA) ? (out_src_r ? hex_q : raw_q) : 8'h00;

endmodule
